### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the integer-to-text formatter.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that also runs while reset is held.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed (reset-time check)");

`endif

### rtl/core/itf_pkg.sv
// Shared types, constants and helper functions of the integer-to-text formatter.
// No dependencies; imported by itf_ctrl, itf_dpath and the top level.
package itf_pkg;

    // Field saturation limit and default digit store depth
    localparam logic [5:0] MAX_FIELD   = 6'd60;
    localparam int         DIGIT_DEPTH = 32;

    // Radix limits
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_HEX = 6'd16;

    // Format flag bit positions
    localparam int FLAG_SIGNED  = 0;
    localparam int FLAG_LEFT    = 1;
    localparam int FLAG_PLUS    = 2;
    localparam int FLAG_SPACE   = 3;
    localparam int FLAG_ZEROPAD = 4;
    localparam int FLAG_LOWER   = 5;
    localparam int FLAG_PREFIX  = 6;

    // ASCII codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;

    typedef enum logic [2:0] {
        CH_NUL,
        CH_SPACE,
        CH_ZERO,
        CH_SIGN,
        CH_X,
        CH_DIGIT
    } t_char_sel;

    // Controller -> datapath
    typedef struct packed {
        logic      load;       // capture input item
        logic      div_step;   // one 8-bit slice of the digit division
        logic      setup;      // size the padding after the last digit
        logic      emit;       // load the output register
        t_char_sel char_sel;
        logic      last;
        logic      bad;
        logic      dec_pad;
        logic      dec_precz;
        logic      dec_dig;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic       bad;
        logic       digit_end;
        logic       quot_zero;
        logic       out_free;
        logic       pad_zero;
        logic       pad_one;
        logic       precz_zero;
        logic       precz_one;
        logic       dig_zero;
        logic       has_sign;
        logic [1:0] pfx_len;
        logic       left;
        logic       zpad;
    } t_status;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
        logic [7:0] ch;
        if (d < 6'd10) begin
            ch = CHAR_0 + 8'(d);
        end else begin
            ch = (lower ? CHAR_LC_A : CHAR_UC_A) + 8'(d) - 8'd10;
        end
        return ch;
    endfunction

endpackage

### rtl/core/itf_ctrl.sv
// Sequencing state machine of the integer-to-text formatter.
// Depends on itf_pkg; drives itf_dpath through t_cmd, reads t_status.
module itf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_in_ready,
    input  itf_pkg::t_status i_status,
    output itf_pkg::t_cmd    o_cmd
);
    import itf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_BAD,
        S_SETUP,
        S_LEAD,
        S_SIGN,
        S_PFX0,
        S_PFXX,
        S_ZPAD,
        S_PRECZ,
        S_DIGIT,
        S_TRAIL
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    logic   dig_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
    assign dig_last   = i_status.dig_zero && (!i_status.left || i_status.pad_zero);

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        cmd.char_sel = CH_NUL;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.bad) begin
                    n_state = S_BAD;
                end else begin
                    cmd.div_step = 1'b1;
                    if (i_status.digit_end && i_status.quot_zero) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_BAD: begin
                if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_NUL;
                    cmd.last     = 1'b1;
                    cmd.bad      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state   = S_LEAD;
            end
            S_LEAD: begin
                if (i_status.pad_zero || i_status.zpad || i_status.left) begin
                    n_state = S_SIGN;
                end else if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_SPACE;
                    cmd.dec_pad  = 1'b1;
                    if (i_status.pad_one) begin
                        n_state = S_SIGN;
                    end
                end
            end
            S_SIGN: begin
                if (!i_status.has_sign) begin
                    n_state = S_PFX0;
                end else if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_SIGN;
                    n_state      = S_PFX0;
                end
            end
            S_PFX0: begin
                if (i_status.pfx_len == 2'd0) begin
                    n_state = S_ZPAD;
                end else if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_ZERO;
                    n_state      = (i_status.pfx_len == 2'd2) ? S_PFXX : S_ZPAD;
                end
            end
            S_PFXX: begin
                if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_X;
                    n_state      = S_ZPAD;
                end
            end
            S_ZPAD: begin
                if (i_status.pad_zero || !i_status.zpad) begin
                    n_state = S_PRECZ;
                end else if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_ZERO;
                    cmd.dec_pad  = 1'b1;
                    if (i_status.pad_one) begin
                        n_state = S_PRECZ;
                    end
                end
            end
            S_PRECZ: begin
                if (i_status.precz_zero) begin
                    n_state = S_DIGIT;
                end else if (i_status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.char_sel  = CH_ZERO;
                    cmd.dec_precz = 1'b1;
                    if (i_status.precz_one) begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_DIGIT;
                    cmd.dec_dig  = 1'b1;
                    cmd.last     = dig_last;
                    if (i_status.dig_zero) begin
                        n_state = dig_last ? S_IDLE : S_TRAIL;
                    end
                end
            end
            S_TRAIL: begin
                if (i_status.pad_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.char_sel = CH_SPACE;
                    cmd.dec_pad  = 1'b1;
                    cmd.last     = i_status.pad_one;
                    if (i_status.pad_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/itf_dpath.sv
// Datapath of the integer-to-text formatter: digit divider, digit store,
// pad counters and the output register. Depends on itf_pkg; run by itf_ctrl.
module itf_dpath #(
    parameter int DIGIT_DEPTH = itf_pkg::DIGIT_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  itf_pkg::t_cmd    i_cmd,
    output itf_pkg::t_status o_status,
    input  logic [31:0]      i_value,
    input  logic [5:0]       i_radix,
    input  logic [5:0]       i_min_width,
    input  logic [5:0]       i_min_digits,
    input  logic [6:0]       i_format_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_character,
    output logic             o_last,
    output logic             o_bad_radix
);
    import itf_pkg::*;

    localparam int CW = $clog2(DIGIT_DEPTH + 1);
    localparam int IW = $clog2(DIGIT_DEPTH);

    // Item context
    logic [31:0]   r_work;
    logic [5:0]    r_rem;
    logic [1:0]    r_byte;
    logic [5:0]    r_base;
    logic [5:0]    r_width_sat;
    logic [5:0]    r_prec_sat;
    logic          r_has_sign;
    logic [7:0]    r_sign_ch;
    logic [1:0]    r_pfx_len;
    logic          r_left;
    logic          r_zpad;
    logic          r_lower;
    logic          r_bad;
    logic [CW-1:0] r_dcount;
    logic [6:0]    r_pad;
    logic [5:0]    r_precz;
    logic [IW-1:0] r_dig_idx;
    logic [IW-1:0] n_dig_idx;
    logic [5:0]    r_rd_data;
    logic [5:0]    mem [DIGIT_DEPTH];

    // Output register
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic          r_out_bad;

    // Input decode
    logic          in_neg;
    logic          in_plus;
    logic          in_space;
    logic          in_pfx_ok;

    // Divider slice
    logic [7:0]    div_q;
    logic [5:0]    div_rem;
    logic [31:0]   n_work;

    // Setup sizing
    logic [6:0]        prec_eff;
    logic signed [7:0] size;

    logic [7:0]    out_char;

    assign in_neg    = i_format_flags[FLAG_SIGNED] && i_value[31];
    assign in_plus   = i_format_flags[FLAG_PLUS];
    assign in_space  = i_format_flags[FLAG_SPACE];
    assign in_pfx_ok = i_format_flags[FLAG_PREFIX];

    // Eight restoring steps on the top byte of the working word
    always_comb begin
        logic [5:0] rem;
        logic [6:0] trial;
        rem   = r_rem;
        div_q = '0;
        for (int i = 0; i < 8; i++) begin
            trial = {rem, r_work[31 - i]};
            if (trial >= {1'b0, r_base}) begin
                trial     = trial - {1'b0, r_base};
                div_q[7 - i] = 1'b1;
            end
            rem = trial[5:0];
        end
        div_rem = rem;
    end

    assign n_work = {r_work[23:0], div_q};

    always_comb begin
        prec_eff = ({1'b0, r_prec_sat} > 7'(r_dcount)) ? {1'b0, r_prec_sat} : 7'(r_dcount);
        size = $signed({2'b00, r_width_sat}) - $signed({7'd0, r_has_sign})
             - $signed({6'd0, r_pfx_len}) - $signed({1'b0, prec_eff});
    end

    always_comb begin
        if (i_cmd.setup) begin
            n_dig_idx = IW'(r_dcount - CW'(1));
        end else if (i_cmd.dec_dig) begin
            n_dig_idx = r_dig_idx - IW'(1);
        end else begin
            n_dig_idx = r_dig_idx;
        end
    end

    always_comb begin
        case (i_cmd.char_sel)
            CH_SPACE: out_char = CHAR_SPACE;
            CH_ZERO:  out_char = CHAR_0;
            CH_SIGN:  out_char = r_sign_ch;
            CH_X:     out_char = r_lower ? CHAR_LC_X : CHAR_UC_X;
            CH_DIGIT: out_char = digit_char(r_rd_data, r_lower);
            default:  out_char = CHAR_NUL;
        endcase
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && r_byte == 2'd3 && r_dcount < CW'(DIGIT_DEPTH)) begin
            mem[r_dcount[IW-1:0]] <= div_rem;
        end
        r_rd_data <= mem[n_dig_idx];
    end

    // Item context and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcount  <= '0;
            r_pad     <= '0;
            r_precz   <= '0;
            r_dig_idx <= '0;
            r_byte    <= '0;
            r_bad     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_work      <= in_neg ? (~i_value + 32'd1) : i_value;
                r_rem       <= '0;
                r_byte      <= '0;
                r_dcount    <= '0;
                r_base      <= i_radix;
                r_bad       <= (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
                r_width_sat <= (i_min_width > MAX_FIELD) ? MAX_FIELD : i_min_width;
                r_prec_sat  <= (i_min_digits > MAX_FIELD) ? MAX_FIELD : i_min_digits;
                r_has_sign  <= in_neg || in_plus || in_space;
                r_sign_ch   <= in_neg ? CHAR_MINUS : (in_plus ? CHAR_PLUS : CHAR_SPACE);
                if (in_pfx_ok && i_radix == RADIX_HEX) begin
                    r_pfx_len <= 2'd2;
                end else if (in_pfx_ok && i_radix == RADIX_OCT) begin
                    r_pfx_len <= 2'd1;
                end else begin
                    r_pfx_len <= 2'd0;
                end
                r_left  <= i_format_flags[FLAG_LEFT];
                r_zpad  <= i_format_flags[FLAG_ZEROPAD] && !i_format_flags[FLAG_LEFT];
                r_lower <= i_format_flags[FLAG_LOWER];
            end
            if (i_cmd.div_step) begin
                r_work <= n_work;
                r_byte <= r_byte + 2'd1;
                if (r_byte == 2'd3) begin
                    r_rem <= '0;
                    if (r_dcount < CW'(DIGIT_DEPTH)) begin
                        r_dcount <= r_dcount + CW'(1);
                    end
                end else begin
                    r_rem <= div_rem;
                end
            end
            if (i_cmd.setup) begin
                r_pad   <= (size > 8'sd0) ? size[6:0] : 7'd0;
                r_precz <= 6'(prec_eff - 7'(r_dcount));
            end
            if (i_cmd.dec_pad) begin
                r_pad <= r_pad - 7'd1;
            end
            if (i_cmd.dec_precz) begin
                r_precz <= r_precz - 6'd1;
            end
            r_dig_idx <= n_dig_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_char <= out_char;
            r_out_last <= i_cmd.last;
            r_out_bad  <= i_cmd.bad;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;
    assign o_bad_radix = r_out_bad;

    always_comb begin
        o_status            = '0;
        o_status.bad        = r_bad;
        o_status.digit_end  = (r_byte == 2'd3);
        o_status.quot_zero  = (n_work == 32'd0);
        o_status.out_free   = !r_out_valid || i_ready;
        o_status.pad_zero   = (r_pad == 7'd0);
        o_status.pad_one    = (r_pad == 7'd1);
        o_status.precz_zero = (r_precz == 6'd0);
        o_status.precz_one  = (r_precz == 6'd1);
        o_status.dig_zero   = (r_dig_idx == '0);
        o_status.has_sign   = r_has_sign;
        o_status.pfx_len    = r_pfx_len;
        o_status.left       = r_left;
        o_status.zpad       = r_zpad;
    end

endmodule

### rtl/core/integer_to_text_formatter_top.sv
// Top level of the integer-to-text formatter: controller plus datapath.
// Depends on itf_pkg, itf_ctrl, itf_dpath and assert_macros.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   input   | in        | i_valid / o_ready   | i_value, i_radix, i_min_width,
//           |           |                     | i_min_digits, i_format_flags
//   output  | out       | o_valid / i_ready   | o_character, o_last, o_bad_radix
//
// Sequence: an accepted item is divided digit by digit (the divider retires
//   8 dividend bits per cycle over the 32-bit value; base 2 gives up to 32
//   digits), then a setup step sizes the padding, then the characters are
//   emitted as the output frees, and empty text sections are passed over.
//   A bad radix yields a single transfer.
// Reset: i_rst_n is synchronous, active low; clears the controller, counters
//   and output valid. The digit store is not cleared.
// Stalls: the output register frees the controller, so the next item can be
//   accepted while the final transfer of the previous one still waits.
`include "assert_macros.svh"

module integer_to_text_formatter_top #(
    parameter int DIGIT_DEPTH = itf_pkg::DIGIT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_radix,
    input  logic [5:0]  i_min_width,
    input  logic [5:0]  i_min_digits,
    input  logic [6:0]  i_format_flags,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic        o_bad_radix
);
    import itf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Controller: walks the text sections in printf order
    itf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_ready (o_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: divider, digit store, pad counters, output register
    itf_dpath #(
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_value        (i_value),
        .i_radix        (i_radix),
        .i_min_width    (i_min_width),
        .i_min_digits   (i_min_digits),
        .i_format_flags (i_format_flags),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_bad_radix    (o_bad_radix)
    );

    // A bad-radix result is always the sole, final transfer of its item
    `ASSERT_CLK(a_bad_is_last, i_clk, i_rst_n, (o_valid && o_bad_radix) |-> o_last)
    // The controller never overwrites a result that is still waiting
    `ASSERT_CLK(a_emit_slot_free, i_clk, i_rst_n, w_cmd.emit |-> (!o_valid || i_ready))
    // The block is not ready in the cycle after an input transfer
    `ASSERT_CLK(a_busy_after_take, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)
    // Reset leaves the output empty and the input open
    `ASSERT_CLK_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!o_valid && o_ready))

endmodule

### bench/tb_top.sv
// Self-checking bench for integer_to_text_formatter_top: printf-style integer text.
// Depends on itf_pkg and the formatter RTL; predicts each character from the item fields.
`timescale 1ns / 1ps

module tb_top;
    import itf_pkg::*;

    // Flag masks built from the package bit positions
    localparam logic [6:0] F_SIGNED  = 7'(1 << FLAG_SIGNED);
    localparam logic [6:0] F_LEFT    = 7'(1 << FLAG_LEFT);
    localparam logic [6:0] F_PLUS    = 7'(1 << FLAG_PLUS);
    localparam logic [6:0] F_SPACE   = 7'(1 << FLAG_SPACE);
    localparam logic [6:0] F_ZEROPAD = 7'(1 << FLAG_ZEROPAD);
    localparam logic [6:0] F_LOWER   = 7'(1 << FLAG_LOWER);
    localparam logic [6:0] F_PREFIX  = 7'(1 << FLAG_PREFIX);

    localparam int RANDOM_ITEMS = 96;
    localparam int IDLE_PCT     = 15;
    localparam int HOLD_CYCLES  = 400;  // long receiver back-pressure, fills the block
    localparam int HOLD_AFTER   = 20;   // items accepted before the hold kicks in
    localparam int CALM_FIRST   = 50;   // window of accepted items with no idling
    localparam int CALM_LAST    = 90;
    localparam int DRAIN_CYCLES = 250;  // > slowest item (base 2)
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  radix;
        logic [5:0]  min_width;
        logic [5:0]  min_digits;
        logic [6:0]  flags;
    } t_fmt_item;

    typedef struct {
        logic [7:0] character;
        logic       last;
        logic       bad_radix;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_ready;
    logic [31:0] in_value = '0;
    logic [5:0]  in_radix = '0;
    logic [5:0]  in_min_width = '0;
    logic [5:0]  in_min_digits = '0;
    logic [6:0]  in_flags = '0;
    logic        o_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  o_character;
    logic        o_last;
    logic        o_bad_radix;

    t_fmt_item  pending_items [$];   // stimulus not yet offered
    t_text_char expected_text [$];   // predicted characters, oldest first
    t_fmt_item  cur_item;
    t_text_char want;

    int items_accepted = 0;
    int chars_checked  = 0;
    int bad_items      = 0;
    int negative_items = 0;
    int mismatches     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit calm;

    integer_to_text_formatter_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_ready        (o_ready),
        .i_value        (in_value),
        .i_radix        (in_radix),
        .i_min_width    (in_min_width),
        .i_min_digits   (in_min_digits),
        .i_format_flags (in_flags),
        .o_valid        (o_valid),
        .i_ready        (out_ready),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_bad_radix    (o_bad_radix)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both sides run without gaps while this many items have gone in
    assign calm = (items_accepted >= CALM_FIRST) && (items_accepted < CALM_LAST);

    // Expected text of one item, appended to expected_text.
    function automatic void predict_text(input t_fmt_item it);
        logic [31:0] mag;
        logic [6:0]  fl;
        logic [5:0]  digits [$];   // least significant first
        logic [7:0]  text [$];
        logic [7:0]  sign_ch;
        logic [5:0]  d;
        bit          has_sign;
        int          width;
        int          prec;
        int          room;
        if (it.radix < RADIX_MIN || it.radix > RADIX_MAX) begin
            // out-of-range base: one flagged NUL and nothing else
            expected_text.push_back('{CHAR_NUL, 1'b1, 1'b1});
            bad_items++;
            return;
        end
        width = (it.min_width > MAX_FIELD) ? int'(MAX_FIELD) : int'(it.min_width);
        prec  = (it.min_digits > MAX_FIELD) ? int'(MAX_FIELD) : int'(it.min_digits);
        fl = it.flags;
        if (fl[FLAG_LEFT])
            fl[FLAG_ZEROPAD] = 1'b0;   // left-justify overrides zero padding

        mag = it.value;
        has_sign = 1'b1;
        if (fl[FLAG_SIGNED] && mag[31]) begin
            sign_ch = CHAR_MINUS;
            mag = 32'd0 - mag;
            negative_items++;
        end else if (fl[FLAG_PLUS]) begin
            sign_ch = CHAR_PLUS;       // plus beats space
        end else if (fl[FLAG_SPACE]) begin
            sign_ch = CHAR_SPACE;
        end else begin
            has_sign = 1'b0;
            sign_ch = CHAR_NUL;
        end

        room = width - int'(has_sign);
        if (fl[FLAG_PREFIX]) begin
            if (it.radix == RADIX_HEX)
                room -= 2;
            else if (it.radix == RADIX_OCT)
                room -= 1;
        end

        // zero still yields one digit
        do begin
            digits.push_back(6'(mag % it.radix));
            mag = mag / it.radix;
        end while (mag != 0);

        if (digits.size() > prec)
            prec = digits.size();
        room -= prec;
        if (room < 0)
            room = 0;

        if (!fl[FLAG_LEFT] && !fl[FLAG_ZEROPAD])
            repeat (room) text.push_back(CHAR_SPACE);
        if (has_sign)
            text.push_back(sign_ch);
        if (fl[FLAG_PREFIX]) begin
            if (it.radix == RADIX_OCT) begin
                text.push_back(CHAR_0);
            end else if (it.radix == RADIX_HEX) begin
                text.push_back(CHAR_0);
                text.push_back(fl[FLAG_LOWER] ? CHAR_LC_X : CHAR_UC_X);
            end
        end
        if (!fl[FLAG_LEFT] && fl[FLAG_ZEROPAD])
            repeat (room) text.push_back(CHAR_0);
        for (int k = digits.size(); k < prec; k++)
            text.push_back(CHAR_0);
        for (int k = digits.size() - 1; k >= 0; k--) begin
            d = digits[k];
            if (d < 6'd10)
                text.push_back(CHAR_0 + 8'(d));
            else
                text.push_back((fl[FLAG_LOWER] ? CHAR_LC_A : CHAR_UC_A) + 8'(d) - 8'd10);
        end
        if (fl[FLAG_LEFT])
            repeat (room) text.push_back(CHAR_SPACE);

        foreach (text[i])
            expected_text.push_back('{text[i], 1'(i == text.size() - 1), 1'b0});
    endfunction

    task automatic add_item(input logic [31:0] value, input logic [5:0] radix,
                            input logic [5:0] min_width, input logic [5:0] min_digits,
                            input logic [6:0] flags);
        pending_items.push_back('{value, radix, min_width, min_digits, flags});
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("%0t: mismatch on %s, got %h, want %h (char #%0d)",
                 $time, what, got, exp_val, chars_checked);
        mismatches++;
    endtask

    // Input driver: a transfer happens when in_valid and o_ready are both high
    // at an edge; the next item (or a gap) is set up in the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready) begin
                predict_text(cur_item);
                items_accepted <= items_accepted + 1;
            end
            if (!in_valid || o_ready) begin
                if (pending_items.size() > 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_item = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    in_value      <= cur_item.value;
                    in_radix      <= cur_item.radix;
                    in_min_width  <= cur_item.min_width;
                    in_min_digits <= cur_item.min_digits;
                    in_flags      <= cur_item.flags;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, one long hold-off early in the run while
    // the driver keeps offering, so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Output monitor: each transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && out_ready) begin
            if (expected_text.size() == 0) begin
                report_mismatch("unexpected character", o_character, CHAR_NUL);
            end else begin
                want = expected_text.pop_front();
                if (o_character !== want.character)
                    report_mismatch("character", o_character, want.character);
                if (o_last !== want.last)
                    report_mismatch("last", 8'(o_last), 8'(want.last));
                if (o_bad_radix !== want.bad_radix)
                    report_mismatch("bad_radix", 8'(o_bad_radix), 8'(want.bad_radix));
            end
            chars_checked <= chars_checked + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [31:0] v;
        logic [5:0]  r;
        logic [5:0]  w;
        logic [5:0]  p;

        // directed corners
        add_item(32'd0, 6'd10, 6'd0, 6'd0, 7'd0);                 // zero value
        add_item(32'hFFFF_FFFF, 6'd2, 6'd0, 6'd0, 7'd0);          // 32 binary digits
        add_item(32'hFFFF_FFFF, 6'd36, 6'd0, 6'd0, F_LOWER);      // top base, lower case
        add_item(32'hFFFF_FFFF, 6'd36, 6'd0, 6'd0, 7'd0);
        add_item(32'h8000_0000, 6'd10, 6'd0, 6'd0, F_SIGNED);     // most negative
        add_item(32'hFFFF_FFFF, 6'd10, 6'd12, 6'd0, F_SIGNED | F_PLUS);
        add_item(32'd0, RADIX_HEX, 6'd0, 6'd0, F_PREFIX);         // prefix on zero
        add_item(32'hDEAD_BEEF, RADIX_HEX, 6'd12, 6'd0, F_PREFIX | F_LOWER | F_ZEROPAD);
        add_item(32'd8, RADIX_OCT, 6'd0, 6'd0, F_PREFIX);
        add_item(32'd255, RADIX_OCT, 6'd10, 6'd5, F_PREFIX | F_LEFT);
        add_item(32'd123, 6'd10, 6'd10, 6'd0, F_LEFT | F_ZEROPAD | F_PLUS);
        add_item(32'd123, 6'd10, 6'd0, 6'd0, F_PLUS | F_SPACE);   // plus beats space
        add_item(32'd123, 6'd10, 6'd6, 6'd0, F_SPACE);
        add_item(32'd5, 6'd10, 6'd63, 6'd0, 7'd0);                // width saturates
        add_item(32'd5, 6'd10, 6'd0, 6'd63, 7'd0);                // precision saturates
        add_item(32'h7FFF_FFFF, 6'd10, 6'd63, 6'd63, 7'h7F);      // every flag
        add_item(32'hFFFF_FFFF, RADIX_HEX, 6'd60, 6'd60, F_SIGNED | F_PREFIX); // 63 chars
        add_item(32'd42, 6'd2, 6'd20, 6'd10, F_ZEROPAD);
        add_item(32'h55AA_55AA, 6'd3, 6'd0, 6'd0, 7'd0);
        add_item(32'd1, RADIX_HEX, 6'd0, 6'd0, F_PREFIX | F_SIGNED);
        add_item(32'd77, 6'd0, 6'd5, 6'd5, 7'h7F);                // bad bases
        add_item(32'd77, 6'd1, 6'd0, 6'd0, 7'd0);
        add_item(32'd77, 6'd37, 6'd0, 6'd0, 7'd0);
        add_item(32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 7'h7F);

        // random items: mostly good bases and modest sizes
        repeat (RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = $urandom_range(1000);
                2: v = 32'd1 << $urandom_range(31);
                default: v = $urandom >> $urandom_range(31);
            endcase
            if ($urandom_range(99) < 8)
                v = 32'd0 - v;
            case ($urandom_range(9))
                0: r = ($urandom_range(1)) ? 6'($urandom_range(1)) : 6'($urandom_range(37, 63));
                1, 2: r = RADIX_HEX;
                3: r = RADIX_OCT;
                4: r = 6'd10;
                default: r = 6'($urandom_range(2, 36));
            endcase
            w = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(16));
            p = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
            add_item(v, r, w, p, 7'($urandom_range(127)));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (pending_items.size() != 0 || in_valid)
            @(posedge i_clk);
        while (expected_text.size() != 0)
            @(posedge i_clk);
        // any stray characters after the last prediction show up here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (%0d bad base, %0d negative), %0d characters checked,",
                 items_accepted, bad_items, negative_items, chars_checked);
        $display("with random gaps on both sides and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d characters still expected", expected_text.size());
        $display("FAIL");
        $finish;
    end

endmodule
